>>> design/plm_pkg.sv
`timescale 1ns / 1ps

package plm_pkg;

  // register map of the configuration channel
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MASTER_GAIN     = 2'd0,
    REG_LIMIT_THRESHOLD = 2'd1,
    REG_RELEASE_FACTOR  = 2'd2
  } cfg_reg_e;

  // entries held between the front and back ends
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_REL,
    ST_SCALE
  } back_state_e;

endpackage

>>> design/plm_channels.sv
`timescale 1ns / 1ps

interface plm_sample_if #(
  parameter int unsigned SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface plm_result_if #(
  parameter int unsigned SAMPLE_BITS = 24,
  parameter int unsigned GAIN_BITS   = 25
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic        [GAIN_BITS-1:0]   gain_now;

  modport source (output valid, output left_out, output right_out, output gain_now,
                  input ready);
  modport sink   (input valid, input left_out, input right_out, input gain_now,
                  output ready);
endinterface

interface plm_cfg_if #(
  parameter int unsigned DATA_BITS = 27
);
  logic                               valid;
  logic                               ready;
  logic [plm_pkg::CFG_IDX_W-1:0]      index;
  logic [DATA_BITS-1:0]               data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> design/stereo_peak_limiter.sv
`timescale 1ns / 1ps

// Stereo peak limiter. Each transfer on in_i carries one stereo pair; both
// samples are scaled by master_gain, rounded and saturated, and the larger
// magnitude drives a limiter gain with instant attack (gain = threshold /
// peak) and exponential release towards one. Each pair yields exactly one
// transfer on out_o with the limited pair and the gain applied. The front end
// takes a pair per cycle, unless a full queue holds its stage, into a
// one-stage pipeline and a two-entry queue; the back end takes one pair at a
// time through a check, a release step or the restoring divider (one quotient
// bit per cycle) and scaling once out_o is free. Registers are written through
// cfg_i (index 0 master_gain, 1 limit_threshold, 2 release_factor, others
// ignored) and must only change while no pair is in flight.
module stereo_peak_limiter #(
  parameter int unsigned SAMPLE_BITS   = 24,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  plm_cfg_if.sink       cfg_i,
  plm_sample_if.sink    in_i,
  plm_result_if.source  out_o
);

  localparam int unsigned MG_W    = FRACTION_BITS + 3;
  localparam int unsigned G_W     = FRACTION_BITS + 1;
  localparam int unsigned ENTRY_W = 3 * SAMPLE_BITS + 2;

  localparam logic [63:0] ONE64     = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] THR_RST64 = (ONE64 * 64'd49 + 64'd49) / 64'd50;
  localparam logic [63:0] REL_RST64 = (ONE64 * 64'd1999) / 64'd2000;

  logic [MG_W-1:0] master_gain_q;
  logic [G_W-1:0]  threshold_q;
  logic [G_W-1:0]  release_q;

  logic                   push, pop;
  logic [ENTRY_W-1:0]     push_data, pop_data;
  plm_pkg::queue_status_t q_status;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      master_gain_q <= MG_W'(ONE64);
      threshold_q   <= G_W'(THR_RST64);
      release_q     <= G_W'(REL_RST64);
    end else if (cfg_i.valid) begin
      case (plm_pkg::cfg_reg_e'(cfg_i.index))
        plm_pkg::REG_MASTER_GAIN:     master_gain_q <= cfg_i.data[MG_W-1:0];
        plm_pkg::REG_LIMIT_THRESHOLD: threshold_q   <= cfg_i.data[G_W-1:0];
        plm_pkg::REG_RELEASE_FACTOR:  release_q     <= cfg_i.data[G_W-1:0];
        default: begin
          master_gain_q <= master_gain_q;
        end
      endcase
    end
  end

  plm_front #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .smp           (in_i),
    .master_gain_i (master_gain_q),
    .q_status_i    (q_status),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  plm_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  plm_back #(
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .entry_i     (pop_data),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .threshold_i (threshold_q),
    .release_i   (release_q),
    .res         (out_o)
  );

endmodule

>>> design/plm_front.sv
`timescale 1ns / 1ps

module plm_front #(
  parameter int unsigned SAMPLE_BITS   = 24,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  plm_sample_if.sink                    smp,
  input  logic [FRACTION_BITS+2:0]      master_gain_i,
  input  plm_pkg::queue_status_t        q_status_i,
  output logic                          push_o,
  output logic [3*SAMPLE_BITS+1:0]      push_data_o
);

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned MG_W = FRACTION_BITS + 3;
  localparam int unsigned PW = SB + MG_W;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRACTION_BITS - 1);
  localparam logic [PW-1:0] SMAX_POS = (PW'(1) << (SB - 1)) - PW'(1);
  localparam logic [PW-1:0] SMAX_NEG = PW'(1) << (SB - 1);

  logic          p_valid_q, p_valid_d;
  logic          l_neg_q, r_neg_q;
  logic [PW-1:0] l_prod_q, r_prod_q;
  logic          accept;

  logic          l_neg_in, r_neg_in;
  logic [SB-1:0] l_mag_in, r_mag_in;

  logic [PW-1:0] l_rnd, r_rnd, l_sat, r_sat;
  logic [SB-1:0] l_m, r_m, peak;
  logic          l_neg_s, r_neg_s;

  // magnitude of the raw sample; the most negative code maps to 2^(SB-1)
  assign l_neg_in = smp.left_in[SB-1];
  assign r_neg_in = smp.right_in[SB-1];
  assign l_mag_in = l_neg_in ? (~smp.left_in + SB'(1)) : smp.left_in;
  assign r_mag_in = r_neg_in ? (~smp.right_in + SB'(1)) : smp.right_in;

  assign push_o    = p_valid_q && !q_status_i.full;
  assign smp.ready = !p_valid_q || !q_status_i.full;
  assign accept    = smp.valid && smp.ready;

  always_comb begin
    p_valid_d = p_valid_q;
    if (accept) begin
      p_valid_d = 1'b1;
    end else if (push_o) begin
      p_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      l_neg_q  <= l_neg_in;
      r_neg_q  <= r_neg_in;
      l_prod_q <= PW'(l_mag_in) * PW'(master_gain_i);
      r_prod_q <= PW'(r_mag_in) * PW'(master_gain_i);
    end
  end

  // round half away from zero on the magnitude, then saturate per sign
  always_comb begin
    l_rnd = (l_prod_q + HALF) >> FRACTION_BITS;
    r_rnd = (r_prod_q + HALF) >> FRACTION_BITS;
    if (l_neg_q) begin
      l_sat = (l_rnd > SMAX_NEG) ? SMAX_NEG : l_rnd;
    end else begin
      l_sat = (l_rnd > SMAX_POS) ? SMAX_POS : l_rnd;
    end
    if (r_neg_q) begin
      r_sat = (r_rnd > SMAX_NEG) ? SMAX_NEG : r_rnd;
    end else begin
      r_sat = (r_rnd > SMAX_POS) ? SMAX_POS : r_rnd;
    end
    l_m = l_sat[SB-1:0];
    r_m = r_sat[SB-1:0];
    // a negative sample that rounds to zero is plain zero
    l_neg_s = l_neg_q && (l_m != '0);
    r_neg_s = r_neg_q && (r_m != '0);
    peak = (l_m > r_m) ? l_m : r_m;
  end

  assign push_data_o = {l_neg_s, l_m, r_neg_s, r_m, peak};

endmodule

>>> design/plm_queue.sv
`timescale 1ns / 1ps

module plm_queue #(
  parameter int unsigned WIDTH = 74
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic [WIDTH-1:0]       push_data_i,
  input  logic                   pop_i,
  output logic [WIDTH-1:0]       pop_data_o,
  output plm_pkg::queue_status_t status_o
);

  localparam int unsigned DEPTH = plm_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == CNT_W'(DEPTH));
  assign pop_data_o     = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full && !pop_i |-> !push_i)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i)
    else $error("queue read while empty");
`endif

endmodule

>>> design/plm_back.sv
`timescale 1ns / 1ps

module plm_back #(
  parameter int unsigned SAMPLE_BITS   = 24,
  parameter int unsigned FRACTION_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [3*SAMPLE_BITS+1:0]      entry_i,
  input  plm_pkg::queue_status_t        q_status_i,
  output logic                          pop_o,
  input  logic [FRACTION_BITS:0]        threshold_i,
  input  logic [FRACTION_BITS:0]        release_i,
  plm_result_if.source                  res
);

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned F     = FRACTION_BITS;
  localparam int unsigned G_W   = F + 1;
  localparam int unsigned SFRAC = SB - 4;
  localparam int unsigned DW    = G_W + SFRAC;
  localparam int unsigned CW    = SB + G_W;
  localparam int unsigned RW    = 2 * G_W;
  localparam int unsigned CNT_W = $clog2(G_W);
  localparam logic [G_W-1:0] ONE = G_W'(1) << F;
  localparam logic [CW-1:0] HALF = CW'(1) << (F - 1);

  plm_pkg::back_state_e state_q, state_d;

  logic          l_neg_q, r_neg_q;
  logic [SB-1:0] l_mag_q, r_mag_q, peak_q;
  logic [G_W-1:0] g_q;
  logic [SB:0]    rem_q;
  logic [G_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;

  logic                 out_valid_q, out_valid_d;
  logic signed [SB-1:0] left_q, right_q;
  logic [G_W-1:0]       gain_q;

  logic out_free, attack, div_last;
  logic load_item, div_load, div_step, rel_load, out_load;

  logic [CW-1:0]  chk_prod, chk_limit;
  logic [DW-1:0]  dividend;
  logic [SB:0]    rem_shift, rem_next;
  logic           q_bit;
  logic [G_W-1:0] quo_next, quo_gain;
  logic [G_W-1:0] rel_eff, g_diff, rel_gain;
  logic [RW-1:0]  rel_prod;
  logic [CW-1:0]  l_scaled, r_scaled;
  logic [SB-1:0]  l_res, r_res;

  assign out_free = !out_valid_q || res.ready;
  assign div_last = (cnt_q == CNT_W'(G_W - 1));

  // attack test: peak * g against the threshold in sample fraction bits
  assign chk_prod  = CW'(peak_q) * CW'(g_q);
  assign chk_limit = CW'(threshold_i) << SFRAC;
  assign attack    = (chk_prod > chk_limit) && (peak_q != '0);

  // restoring divider, one quotient bit per cycle; the high part of the
  // dividend is already below the peak, so G_W quotient bits suffice
  assign dividend  = {threshold_i, SFRAC'(0)};
  assign rem_shift = {rem_q[SB-1:0], quo_q[G_W-1]};
  assign q_bit     = (rem_shift >= (SB+1)'(peak_q));
  assign rem_next  = q_bit ? (rem_shift - (SB+1)'(peak_q)) : rem_shift;
  assign quo_next  = {quo_q[G_W-2:0], q_bit};
  assign quo_gain  = (quo_next > ONE) ? ONE : quo_next;

  // release: shrink the gain reduction by the release factor
  assign rel_eff  = (release_i > ONE) ? ONE : release_i;
  assign g_diff   = ONE - g_q;
  assign rel_prod = RW'(g_diff) * RW'(rel_eff);
  assign rel_gain = ONE - G_W'(rel_prod >> F);

  assign l_scaled = (CW'(l_mag_q) * CW'(g_q) + HALF) >> F;
  assign r_scaled = (CW'(r_mag_q) * CW'(g_q) + HALF) >> F;
  assign l_res    = l_scaled[SB-1:0];
  assign r_res    = r_scaled[SB-1:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      plm_pkg::ST_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = plm_pkg::ST_CHECK;
        end
      end
      plm_pkg::ST_CHECK: begin
        state_d = attack ? plm_pkg::ST_DIV : plm_pkg::ST_REL;
      end
      plm_pkg::ST_DIV: begin
        if (div_last) begin
          state_d = plm_pkg::ST_SCALE;
        end
      end
      plm_pkg::ST_REL: begin
        state_d = plm_pkg::ST_SCALE;
      end
      plm_pkg::ST_SCALE: begin
        if (out_free) begin
          state_d = plm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = plm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    load_item = 1'b0;
    div_load  = 1'b0;
    div_step  = 1'b0;
    rel_load  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      plm_pkg::ST_IDLE:  load_item = !q_status_i.empty;
      plm_pkg::ST_CHECK: div_load  = attack;
      plm_pkg::ST_DIV:   div_step  = 1'b1;
      plm_pkg::ST_REL:   rel_load  = 1'b1;
      plm_pkg::ST_SCALE: out_load  = out_free;
      default: begin
        load_item = 1'b0;
      end
    endcase
  end

  assign pop_o = load_item;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plm_pkg::ST_IDLE;
      g_q         <= ONE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (div_load) begin
        cnt_q <= '0;
      end else if (div_step) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (div_step && div_last) begin
        g_q <= quo_gain;
      end else if (rel_load) begin
        g_q <= rel_gain;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_item) begin
      {l_neg_q, l_mag_q, r_neg_q, r_mag_q, peak_q} <= entry_i;
    end
    if (div_load) begin
      rem_q <= (SB+1)'(dividend[DW-1:G_W]);
      quo_q <= dividend[G_W-1:0];
    end else if (div_step) begin
      rem_q <= rem_next;
      quo_q <= quo_next;
    end
    if (out_load) begin
      left_q  <= l_neg_q ? (~l_res + SB'(1)) : l_res;
      right_q <= r_neg_q ? (~r_res + SB'(1)) : r_res;
      gain_q  <= g_q;
    end
  end

  assign res.valid     = out_valid_q;
  assign res.left_out  = left_q;
  assign res.right_out = right_q;
  assign res.gain_now  = gain_q;

`ifndef SYNTHESIS
  a_gain_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    g_q <= ONE)
    else $error("limiter gain above one");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plm_pkg::ST_DIV) |-> (cnt_q <= CNT_W'(G_W - 1)))
    else $error("divider ran past its last step");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == plm_pkg::ST_SCALE) && out_free |=>
      out_valid_q && (state_q == plm_pkg::ST_IDLE))
    else $error("scaled pair not presented");
`endif

endmodule

>>> tb/tb_stereo_peak_limiter.sv
`timescale 1ns / 1ps

module tb_stereo_peak_limiter;

  localparam int unsigned SAMPLE_W = 24;
  localparam int unsigned FRAC_W   = 24;
  localparam int unsigned GAIN_W   = 25;
  localparam int unsigned CFG_W    = 27;
  localparam int unsigned SFRAC    = SAMPLE_W - 4;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PHASE_PAIRS = 200;
  localparam int unsigned N_DIR       = 31;
  localparam int unsigned MAX_PRINTS  = 40;

  localparam int unsigned CFG_IDX_W = plm_pkg::CFG_IDX_W;

  typedef longint unsigned u64_t;

  localparam u64_t ONE      = 64'd1 << FRAC_W;
  localparam u64_t HALF     = 64'd1 << (FRAC_W - 1);
  localparam u64_t SPAN     = 64'd1 << SAMPLE_W;
  localparam u64_t MAX_NEG  = 64'd1 << (SAMPLE_W - 1);
  localparam u64_t MAX_POS  = MAX_NEG - 1;

  // register indexes as the block decodes them
  localparam logic [CFG_IDX_W-1:0] REG_MASTER_GAIN     = plm_pkg::REG_MASTER_GAIN;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_THRESHOLD = plm_pkg::REG_LIMIT_THRESHOLD;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_FACTOR  = plm_pkg::REG_RELEASE_FACTOR;

  // index 3 is not mapped; writes to it must leave every register alone
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] NO_REG       = REG_MASTER_GAIN;

  typedef enum bit {ROW_PAIR, ROW_REG} row_kind_e;
  typedef enum int {MOOD_SILENT, MOOD_QUIET, MOOD_LOUD, MOOD_WILD} mood_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [CFG_IDX_W-1:0]   sel;
    logic [CFG_W-1:0]       value;
    logic [SAMPLE_W-1:0]    l;
    logic [SAMPLE_W-1:0]    r;
    bit                     known;
    logic [SAMPLE_W-1:0]    el;
    logic [SAMPLE_W-1:0]    er;
    logic [GAIN_W-1:0]      eg;
  } stim_row_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic        [GAIN_W-1:0]   gain;
  } pair_out_t;

  typedef struct {
    bit        known;
    pair_out_t want;
  } typed_row_t;

  // directed rows: expected values filled in only where they are obvious
  stim_row_t dir_rows [0:N_DIR-1] = '{
    '{ROW_PAIR, NO_REG, 27'd0, 24'd0, 24'd0, 1'b1, 24'd0, 24'd0, 25'd16777216},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd524288, -24'sd524288,
      1'b1, 24'd524288, -24'sd524288, 25'd16777216},
    '{ROW_REG, REG_UNMAPPED, 27'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'h7fffff, 24'h800000, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'h800000, 24'h7fffff, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'hffffff, 24'd1, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_REG, REG_MASTER_GAIN, 27'd67108864, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'h7fffff, 24'h800000, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd3000000, -24'sd3000000, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd100, -24'sd100, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_REG, REG_MASTER_GAIN, 27'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'h7fffff, 24'h800000, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_REG, REG_MASTER_GAIN, 27'h7ffffff, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd5000, -24'sd7000, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_REG, REG_MASTER_GAIN, 27'd16777216, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_REG, REG_RELEASE_FACTOR, 27'h1ffffff, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'h7fffff, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd1000, 24'd1000, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_REG, REG_LIMIT_THRESHOLD, 27'h1ffffff, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'h7fffff, 24'h7fffff, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_REG, REG_LIMIT_THRESHOLD, 27'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd1, 24'hffffff, 1'b1, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd0, 24'd0, 1'b1, 24'd0, 24'd0, 25'd0},
    '{ROW_REG, REG_RELEASE_FACTOR, 27'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd0, 24'd0, 1'b1, 24'd0, 24'd0, 25'd16777216},
    '{ROW_REG, REG_LIMIT_THRESHOLD, 27'h4fae148, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_REG, REG_RELEASE_FACTOR, 27'h6ffdf3b, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd4194304, -24'sd4194304, 1'b0, 24'd0, 24'd0, 25'd0},
    '{ROW_PAIR, NO_REG, 27'd0, 24'd0, 24'd0, 1'b0, 24'd0, 24'd0, 25'd0}
  };

  logic clk_i;
  logic rst_ni;

  plm_sample_if #(.SAMPLE_BITS(SAMPLE_W))                   pair_if ();
  plm_result_if #(.SAMPLE_BITS(SAMPLE_W), .GAIN_BITS(GAIN_W)) limited_if ();
  plm_cfg_if    #(.DATA_BITS(CFG_W))                        reg_if ();

  stereo_peak_limiter #(
    .SAMPLE_BITS  (SAMPLE_W),
    .FRACTION_BITS(FRAC_W)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (reg_if),
    .in_i  (pair_if),
    .out_o (limited_if)
  );

  // predictor state, reset values of the block
  u64_t cur_master  = ONE;
  u64_t cur_thresh  = 64'd16441672;
  u64_t cur_release = 64'd16768827;
  u64_t lim_gain    = ONE;

  pair_out_t  limited_due [$];
  typed_row_t typed_due [$];

  int unsigned src_idle_pct = 6;
  int unsigned snk_idle_pct = 87;
  bit          hold_req     = 1'b0;
  int unsigned n_sent   = 0;
  int unsigned n_done   = 0;
  int unsigned n_writes = 0;
  int unsigned n_errors = 0;
  int unsigned quiet_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // scale a magnitude, round half away from zero, saturate by sign
  function automatic logic [SAMPLE_W-1:0] apply_gain(input bit neg, input u64_t mag,
                                                     input u64_t gain, output u64_t m_o);
    u64_t m;
    u64_t t;
    m = (mag * gain + HALF) >> FRAC_W;
    if (neg && m > MAX_NEG) m = MAX_NEG;
    else if (!neg && m > MAX_POS) m = MAX_POS;
    m_o = m;
    t = neg ? (64'd0 - m) : m;
    return t[SAMPLE_W-1:0];
  endfunction

  function automatic pair_out_t limit_pair(input logic [SAMPLE_W-1:0] l_raw,
                                           input logic [SAMPLE_W-1:0] r_raw);
    bit        ln, rn;
    u64_t      lm, rm, lsm, rsm, peak, g, rel, ceiling;
    pair_out_t res;
    ln = l_raw[SAMPLE_W-1];
    rn = r_raw[SAMPLE_W-1];
    lm = u64_t'(l_raw);
    rm = u64_t'(r_raw);
    if (ln) lm = SPAN - lm;
    if (rn) rm = SPAN - rm;
    void'(apply_gain(ln, lm, cur_master, lsm));
    void'(apply_gain(rn, rm, cur_master, rsm));
    // a negative sample rounded to zero loses its sign
    ln = ln && (lsm != 0);
    rn = rn && (rsm != 0);
    peak = (lsm > rsm) ? lsm : rsm;
    g = lim_gain;
    ceiling = cur_thresh << SFRAC;
    if (peak != 0 && peak * g > ceiling) begin
      g = ceiling / peak;
    end else begin
      rel = (cur_release > ONE) ? ONE : cur_release;
      g = ONE - (((ONE - g) * rel) >> FRAC_W);
    end
    if (g > ONE) g = ONE;
    lim_gain = g;
    res.left  = apply_gain(ln, lsm, g, lm);
    res.right = apply_gain(rn, rsm, g, rm);
    res.gain  = g[GAIN_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    n_errors++;
    if (n_errors <= MAX_PRINTS)
      $display("%0t: %s mismatch at pair %0d: got %0d, expected %0d",
               $realtime, what, n_done, got, want);
  endtask

  always @(posedge clk_i) begin : scoreboard
    pair_out_t  want;
    typed_row_t row;
    if (rst_ni) begin
      if (reg_if.valid && reg_if.ready) begin
        case (reg_if.index)
          REG_MASTER_GAIN:     cur_master  = u64_t'(reg_if.data);
          REG_LIMIT_THRESHOLD: cur_thresh  = u64_t'(reg_if.data[GAIN_W-1:0]);
          REG_RELEASE_FACTOR:  cur_release = u64_t'(reg_if.data[GAIN_W-1:0]);
          default: ;
        endcase
      end
      if (limited_if.valid && limited_if.ready) begin
        if (limited_due.size() == 0) begin
          flag_mismatch("unexpected transfer", 0, 0);
        end else begin
          want = limited_due.pop_front();
          if (limited_if.left_out !== want.left)
            flag_mismatch("left_out", limited_if.left_out, want.left);
          if (limited_if.right_out !== want.right)
            flag_mismatch("right_out", limited_if.right_out, want.right);
          if (limited_if.gain_now !== want.gain)
            flag_mismatch("gain_now", limited_if.gain_now, want.gain);
        end
        n_done++;
      end
      if (pair_if.valid && pair_if.ready) begin
        want = limit_pair(pair_if.left_in, pair_if.right_in);
        row = typed_due.pop_front();
        if (row.known) want = row.want;
        limited_due.insert(limited_due.size(), want);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((reg_if.valid && reg_if.ready) || (pair_if.valid && pair_if.ready) ||
          (limited_if.valid && limited_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, limited_due.size());
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // output side: random back-pressure, plus one long hold-off on request
  initial begin
    limited_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        limited_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        limited_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  task automatic wait_drained();
    pair_if.valid <= 1'b0;
    while (n_done != n_sent) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_W-1:0] value);
    wait_drained();
    reg_if.valid <= 1'b1;
    reg_if.index <= sel;
    reg_if.data  <= value;
    @(posedge clk_i);
    while (!reg_if.ready) @(posedge clk_i);
    n_writes++;
  endtask

  task automatic send_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                           input typed_row_t typed);
    reg_if.valid <= 1'b0;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      pair_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    typed_due.insert(typed_due.size(), typed);
    pair_if.valid    <= 1'b1;
    pair_if.left_in  <= l;
    pair_if.right_in <= r;
    @(posedge clk_i);
    while (!pair_if.ready) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic pick_settings();
    logic [CFG_W-1:0] mg, th, rf;
    case ($urandom_range(0, 7))
      0:       mg = '0;
      1:       mg = 27'd67108864;
      2:       mg = CFG_W'($urandom());
      default: mg = CFG_W'($urandom_range(32'(ONE / 2), 32'(3 * ONE)));
    endcase
    case ($urandom_range(0, 7))
      0:       th = '0;
      1:       th = CFG_W'($urandom());
      default: th = CFG_W'($urandom_range(32'(ONE / 4), 32'(ONE)));
    endcase
    case ($urandom_range(0, 7))
      0:       rf = CFG_W'(ONE);
      1:       rf = CFG_W'($urandom());
      2:       rf = CFG_W'($urandom_range(0, 32'(ONE)));
      default: rf = CFG_W'(ONE - u64_t'($urandom_range(32'(ONE / 256), 32'(ONE / 8))));
    endcase
    write_reg(REG_MASTER_GAIN, mg);
    write_reg(REG_LIMIT_THRESHOLD, th);
    write_reg(REG_RELEASE_FACTOR, rf);
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample(input mood_e mood);
    u64_t mag;
    u64_t t;
    case (mood)
      MOOD_SILENT: mag = 0;
      MOOD_QUIET:  mag = u64_t'($urandom_range(0, 1 << 18));
      MOOD_LOUD:   mag = u64_t'($urandom_range(1 << 19, 1 << 23));
      default:     return SAMPLE_W'($urandom());
    endcase
    t = $urandom_range(0, 1) ? (64'd0 - mag) : mag;
    return t[SAMPLE_W-1:0];
  endfunction

  initial begin : stimulus
    typed_row_t typed;
    typed_row_t blind;
    mood_e      mood;
    int         run_left;
    int unsigned pick;
    rst_ni           <= 1'b0;
    pair_if.valid    <= 1'b0;
    pair_if.left_in  <= '0;
    pair_if.right_in <= '0;
    reg_if.valid     <= 1'b0;
    reg_if.index     <= '0;
    reg_if.data      <= '0;
    blind.known = 1'b0;
    blind.want  = '{default: '0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_REG) begin
        write_reg(dir_rows[k].sel, dir_rows[k].value);
      end else begin
        typed.known      = dir_rows[k].known;
        typed.want.left  = dir_rows[k].el;
        typed.want.right = dir_rows[k].er;
        typed.want.gain  = dir_rows[k].eg;
        send_pair(dir_rows[k].l, dir_rows[k].r, typed);
      end
    end

    // loud and quiet stretches so that attack and long releases both occur
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 6;
          snk_idle_pct = 87;
        end
        1: begin
          src_idle_pct = 87;
          snk_idle_pct = 6;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      pick_settings();
      run_left = 0;
      mood = MOOD_QUIET;
      for (int i = 0; i < PHASE_PAIRS; i++) begin
        if (phase == 0 && i == PHASE_PAIRS / 2) pick_settings();
        if (phase == 1 && i == PHASE_PAIRS / 2) wait_drained();
        if (phase == 2 && i == 40) hold_req = 1'b1;
        if (run_left == 0) begin
          pick = $urandom_range(0, 99);
          if (pick < 15)      mood = MOOD_SILENT;
          else if (pick < 50) mood = MOOD_QUIET;
          else if (pick < 85) mood = MOOD_LOUD;
          else                mood = MOOD_WILD;
          run_left = $urandom_range(1, 24);
        end
        run_left--;
        send_pair(rand_sample(mood), rand_sample(mood), blind);
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (limited_due.size() != 0) flag_mismatch("results missing", limited_due.size(), 0);
    $display("limiter: %0d pairs checked (%0d directed rows), %0d register writes",
             n_done, N_DIR, n_writes);
    $display("three idling mixes, one output hold-off, one input drain; %0d mismatches",
             n_errors);
    if (n_errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
